### hw/rtl/ttlc_pkg.sv
// Package for the transport loop counter: field widths, command and run codes,
// and the control word of the shared arithmetic unit. No dependencies.
package ttlc_pkg;

  localparam int unsigned KIND_W    = 3;
  localparam int unsigned BLK_W     = 16;
  localparam int unsigned BAR_W     = 16;
  localparam int unsigned BEAT_W    = 22;
  localparam int unsigned RUN_W     = 2;
  localparam int unsigned POS_OUT_W = 48;
  localparam int unsigned SPB_W     = 32;
  localparam int unsigned BPB_W     = 6;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_W     = 32;
  localparam int unsigned MCAND_W   = 40;
  localparam int unsigned PROD_W    = MCAND_W + SPB_W;
  localparam int unsigned T_W       = 41;
  localparam int unsigned BEAT_FRAC = 16;
  localparam int unsigned SPB_FRAC  = 12;
  localparam int unsigned POS_SHIFT = 28;

  typedef enum logic [KIND_W-1:0] {
    KIND_ADVANCE = 3'd0,
    KIND_PLAY    = 3'd1,
    KIND_PAUSE   = 3'd2,
    KIND_STOP    = 3'd3,
    KIND_TOGGLE  = 3'd4,
    KIND_SEEK    = 3'd5,
    KIND_QUERY   = 3'd6
  } kind_e;

  typedef enum logic [RUN_W-1:0] {
    RUN_STOPPED = 2'd0,
    RUN_PLAYING = 2'd1,
    RUN_PAUSED  = 2'd2
  } run_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SPB        = 3'd0,
    CFG_BPB        = 3'd1,
    CFG_LOOP_EN    = 3'd2,
    CFG_LOOP_START = 3'd3,
    CFG_LOOP_END   = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic mul_load;
    logic div_load;
    logic step;
  } unit_cmd_t;

endpackage

### hw/rtl/ttlc_if.sv
// Item channel interfaces of the transport loop counter.
// Depends on ttlc_pkg for the field widths.
interface ttlc_in_if import ttlc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [BLK_W-1:0]  block_samples;
  logic [BAR_W-1:0]  target_bar;
  logic [BEAT_W-1:0] target_beat;

  modport source (output valid, kind, block_samples, target_bar, target_beat, input ready);
  modport sink (input valid, kind, block_samples, target_bar, target_beat, output ready);
endinterface

interface ttlc_out_if import ttlc_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [RUN_W-1:0]     run_status;
  logic [POS_OUT_W-1:0] position_samples;
  logic [BAR_W-1:0]     bar_number;
  logic [BEAT_W-1:0]    beat_in_bar;
  logic                 note_due;

  modport source (output valid, run_status, position_samples, bar_number, beat_in_bar,
                  note_due, input ready);
  modport sink (input valid, run_status, position_samples, bar_number, beat_in_bar,
                note_due, output ready);
endinterface

### hw/rtl/tempo_transport_loop_counter.sv
// Top level of the musical transport: run state, sample position, loop wrap,
// and bar and beat reporting. Depends on ttlc_pkg, ttlc_if and ttlc_unit.
//
// Each item is one transport command and gives one result. The block takes one
// item at a time. An item needs one multiplication for a seek or a note query
// while playing, and one for an advance while playing with the loop active, or
// two when it reaches the loop end. The shared unit divides and multiplies one
// bit per cycle: when samples per beat is nonzero, bar and beat come from two
// divisions of the position, by samples per beat and then by beats per bar.
// A finished result waits in the output register while the next item starts.
module tempo_transport_loop_counter import ttlc_pkg::*; #(
  parameter int unsigned POSITION_BITS = 48
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  ttlc_in_if.sink              in_i,
  ttlc_out_if.source           out_o
);

  localparam int unsigned PB    = POSITION_BITS;
  localparam int unsigned DIV_W = PB + POS_SHIFT;
  localparam int unsigned CMP_W = (DIV_W > PROD_W) ? DIV_W : PROD_W;
  localparam int unsigned CNT_W = $clog2(DIV_W);
  localparam int unsigned PX_W  = PB + POS_OUT_W;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MUL_END, ST_CHK_END, ST_MUL_LEN, ST_APPLY_LEN, ST_MUL_T, ST_APPLY_T,
    ST_DIV_START, ST_DIV_S, ST_DIV_N_LOAD, ST_DIV_N, ST_CALC, ST_FINISH
  } state_e;

  state_e             state_q;
  logic [CNT_W-1:0]   cnt_q;
  run_e               run_q;
  logic [PB-1:0]      pos_q;
  logic               due_q;
  logic               seek_q;
  logic [BAR_W-1:0]   bar_q;
  logic [BEAT_W-1:0]  beat_q;
  logic [15:0]        frac_q;
  logic [SPB_W-1:0]   spb_q;
  logic [BPB_W-1:0]   bpb_q;
  logic               loop_en_q;
  logic [BAR_W-1:0]   loop_start_q;
  logic [BAR_W-1:0]   loop_end_q;
  logic               out_valid_q;
  logic [RUN_W-1:0]   o_run_q;
  logic [PB-1:0]      o_pos_q;
  logic [BAR_W-1:0]   o_bar_q;
  logic [BEAT_W-1:0]  o_beat_q;
  logic               o_due_q;

  unit_cmd_t          cmd;
  logic [MCAND_W-1:0] mcand;
  logic [DIV_W-1:0]   dividend;
  logic [SPB_W-1:0]   divisor;
  logic [PROD_W-1:0]  prod;
  logic [DIV_W-1:0]   quot;
  logic [SPB_W-1:0]   rem;

  logic               in_fire;
  logic [BPB_W-1:0]   n_eff;
  logic               spb_zero;
  logic               loop_act;
  logic [PB:0]        adv_sum;
  logic [PB-1:0]      adv_pos;
  logic signed [17:0] bar_m1;
  logic signed [24:0] bar_beats;
  logic signed [T_W-1:0] t_s;
  logic               t_pos;
  logic [MCAND_W-1:0] end_beats;
  logic [MCAND_W-1:0] len_beats;
  logic [PROD_W-1:0]  endc;
  logic [PROD_W-1:0]  pos_x;
  logic               pos_ge_endc;
  logic [PROD_W-1:0]  wrap_pos;
  logic [PROD_W-1:0]  seek_p;
  logic               seek_sat;
  logic               due_cmp;
  logic [PX_W-1:0]    o_pos_x;
  logic               out_free;

  assign in_fire  = in_i.valid && in_i.ready;
  assign out_free = !out_valid_q || out_o.ready;
  assign n_eff    = (bpb_q == '0) ? BPB_W'(1) : bpb_q;
  assign spb_zero = (spb_q == '0);
  assign loop_act = loop_en_q && (loop_end_q > loop_start_q);
  assign adv_sum  = {1'b0, pos_q} + (PB + 1)'(in_i.block_samples);
  assign adv_pos  = adv_sum[PB] ? {PB{1'b1}} : adv_sum[PB-1:0];

  assign bar_m1    = $signed({2'b00, in_i.target_bar}) - 18'sd1;
  assign bar_beats = bar_m1 * $signed({1'b0, n_eff});
  assign t_s       = (T_W'(bar_beats) <<< BEAT_FRAC) + $signed(T_W'(in_i.target_beat))
                     - $signed(T_W'(1 << BEAT_FRAC));
  assign t_pos     = (t_s > 0);

  assign end_beats = MCAND_W'((loop_end_q - BAR_W'(1)) * n_eff);
  assign len_beats = MCAND_W'((loop_end_q - loop_start_q) * n_eff);
  assign endc      = (prod >> SPB_FRAC) + PROD_W'(|prod[SPB_FRAC-1:0]);
  assign pos_x     = PROD_W'(pos_q);
  assign pos_ge_endc = (pos_x >= endc);
  assign wrap_pos  = (pos_x > endc) ? pos_x - endc : '0;
  assign seek_p    = prod >> POS_SHIFT;
  assign seek_sat  = (seek_p > PROD_W'({PB{1'b1}}));
  assign due_cmp   = (CMP_W'(prod) <= CMP_W'({pos_q, {POS_SHIFT{1'b0}}}));

  always_comb begin
    cmd      = '0;
    mcand    = MCAND_W'(t_s[MCAND_W-1:0]);
    dividend = {pos_q, {POS_SHIFT{1'b0}}};
    divisor  = spb_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          case (kind_e'(in_i.kind))
            KIND_ADVANCE: begin
              cmd.mul_load = (run_q == RUN_PLAYING) && loop_act;
              mcand        = end_beats;
            end
            KIND_SEEK: cmd.mul_load = t_pos && !spb_zero;
            KIND_QUERY: cmd.mul_load = (run_q == RUN_PLAYING) && t_pos && !spb_zero;
            default: cmd.mul_load = 1'b0;
          endcase
        end
      end
      ST_CHK_END: begin
        cmd.mul_load = pos_ge_endc;
        mcand        = len_beats;
      end
      ST_DIV_START: cmd.div_load = !spb_zero;
      ST_DIV_N_LOAD: begin
        cmd.div_load = 1'b1;
        dividend     = quot >> BEAT_FRAC;
        divisor      = SPB_W'(n_eff);
      end
      ST_MUL_END, ST_MUL_LEN, ST_MUL_T, ST_DIV_S, ST_DIV_N: cmd.step = 1'b1;
      default: cmd = '0;
    endcase
  end

  ttlc_unit #(
    .DIV_W(DIV_W)
  ) u_unit (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .mcand_i    (mcand),
    .mplier_i   (spb_q),
    .dividend_i (dividend),
    .divisor_i  (divisor),
    .prod_o     (prod),
    .quot_o     (quot),
    .rem_o      (rem)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spb_q        <= SPB_W'(98304000);
      bpb_q        <= BPB_W'(4);
      loop_en_q    <= 1'b0;
      loop_start_q <= BAR_W'(1);
      loop_end_q   <= BAR_W'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_SPB:        spb_q        <= cfg_data_i[SPB_W-1:0];
        CFG_BPB:        bpb_q        <= cfg_data_i[BPB_W-1:0];
        CFG_LOOP_EN:    loop_en_q    <= cfg_data_i[0];
        CFG_LOOP_START: loop_start_q <= cfg_data_i[BAR_W-1:0];
        CFG_LOOP_END:   loop_end_q   <= cfg_data_i[BAR_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      run_q       <= RUN_STOPPED;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
      due_q       <= 1'b0;
      seek_q      <= 1'b0;
      bar_q       <= BAR_W'(1);
      beat_q      <= BEAT_W'(1 << BEAT_FRAC);
      frac_q      <= '0;
      o_run_q     <= '0;
      o_pos_q     <= '0;
      o_bar_q     <= '0;
      o_beat_q    <= '0;
      o_due_q     <= 1'b0;
    end else begin
      if (out_valid_q && out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            due_q  <= 1'b0;
            seek_q <= (kind_e'(in_i.kind) == KIND_SEEK);
            cnt_q  <= '0;
            state_q <= ST_DIV_START;
            case (kind_e'(in_i.kind))
              KIND_ADVANCE: begin
                if (run_q == RUN_PLAYING) begin
                  pos_q <= adv_pos;
                  if (loop_act) begin
                    state_q <= ST_MUL_END;
                  end
                end
              end
              KIND_PLAY:  run_q <= RUN_PLAYING;
              KIND_PAUSE: run_q <= RUN_PAUSED;
              KIND_STOP: begin
                run_q <= RUN_STOPPED;
                pos_q <= '0;
              end
              KIND_TOGGLE: run_q <= (run_q == RUN_PLAYING) ? RUN_PAUSED : RUN_PLAYING;
              KIND_SEEK: begin
                if (t_pos && !spb_zero) begin
                  state_q <= ST_MUL_T;
                end else begin
                  pos_q <= '0;
                end
              end
              KIND_QUERY: begin
                if (run_q == RUN_PLAYING) begin
                  if (!t_pos) begin
                    due_q <= 1'b1;
                  end else if (!spb_zero) begin
                    state_q <= ST_MUL_T;
                  end
                end
              end
              default: ;
            endcase
          end
        end
        ST_MUL_END, ST_MUL_LEN, ST_MUL_T: begin
          cnt_q <= cnt_q + CNT_W'(1);
          if (cnt_q == CNT_W'(SPB_W - 1)) begin
            cnt_q <= '0;
            case (state_q)
              ST_MUL_END: state_q <= ST_CHK_END;
              ST_MUL_LEN: state_q <= ST_APPLY_LEN;
              default:    state_q <= ST_APPLY_T;
            endcase
          end
        end
        ST_CHK_END: state_q <= pos_ge_endc ? ST_MUL_LEN : ST_DIV_START;
        ST_APPLY_LEN: begin
          pos_q   <= wrap_pos[PB-1:0];
          state_q <= ST_DIV_START;
        end
        ST_APPLY_T: begin
          if (seek_q) begin
            pos_q <= seek_sat ? {PB{1'b1}} : seek_p[PB-1:0];
          end else begin
            due_q <= due_cmp;
          end
          state_q <= ST_DIV_START;
        end
        ST_DIV_START: begin
          cnt_q <= '0;
          if (spb_zero) begin
            bar_q   <= BAR_W'(1);
            beat_q  <= BEAT_W'(1 << BEAT_FRAC);
            state_q <= ST_FINISH;
          end else begin
            state_q <= ST_DIV_S;
          end
        end
        ST_DIV_S, ST_DIV_N: begin
          cnt_q <= cnt_q + CNT_W'(1);
          if (cnt_q == CNT_W'(DIV_W - 1)) begin
            cnt_q   <= '0;
            state_q <= (state_q == ST_DIV_S) ? ST_DIV_N_LOAD : ST_CALC;
          end
        end
        ST_DIV_N_LOAD: begin
          frac_q  <= quot[15:0];
          state_q <= ST_DIV_N;
        end
        ST_CALC: begin
          bar_q   <= (quot >= DIV_W'(65534)) ? {BAR_W{1'b1}} : quot[BAR_W-1:0] + BAR_W'(1);
          beat_q  <= {rem[BPB_W-1:0] + BPB_W'(1), frac_q};
          state_q <= ST_FINISH;
        end
        ST_FINISH: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            o_run_q     <= run_q;
            o_pos_q     <= pos_q;
            o_bar_q     <= bar_q;
            o_beat_q    <= beat_q;
            o_due_q     <= due_q;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign o_pos_x = PX_W'(o_pos_q);

  assign in_i.ready             = (state_q == ST_IDLE);
  assign out_o.valid            = out_valid_q;
  assign out_o.run_status       = o_run_q;
  assign out_o.position_samples = o_pos_x[POS_OUT_W-1:0];
  assign out_o.bar_number       = o_bar_q;
  assign out_o.beat_in_bar      = o_beat_q;
  assign out_o.note_due         = o_due_q;

endmodule

### hw/rtl/ttlc_unit.sv
// Shared arithmetic unit: a shift-add multiplier and a restoring divider,
// one bit per step. Depends on ttlc_pkg.
module ttlc_unit import ttlc_pkg::*; #(
  parameter int unsigned DIV_W = 76
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  unit_cmd_t          cmd_i,
  input  logic [MCAND_W-1:0] mcand_i,
  input  logic [SPB_W-1:0]   mplier_i,
  input  logic [DIV_W-1:0]   dividend_i,
  input  logic [SPB_W-1:0]   divisor_i,
  output logic [PROD_W-1:0]  prod_o,
  output logic [DIV_W-1:0]   quot_o,
  output logic [SPB_W-1:0]   rem_o
);

  logic               mul_mode_q;
  logic [PROD_W-1:0]  acc_q;
  logic [MCAND_W-1:0] mc_q;
  logic [SPB_W-1:0]   mp_q;
  logic [DIV_W-1:0]   dq_q;
  logic [SPB_W-1:0]   r_q;
  logic [SPB_W-1:0]   dv_q;
  logic [PROD_W-1:0]  madd;
  logic [SPB_W:0]     rs;
  logic [SPB_W:0]     rdiff;
  logic               ge;

  assign madd  = {acc_q[PROD_W-2:0], 1'b0} + (mp_q[SPB_W-1] ? PROD_W'(mc_q) : '0);
  assign rs    = {r_q, dq_q[DIV_W-1]};
  assign rdiff = rs - {1'b0, dv_q};
  assign ge    = (rs >= {1'b0, dv_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_mode_q <= 1'b0;
    end else if (cmd_i.mul_load) begin
      mul_mode_q <= 1'b1;
    end else if (cmd_i.div_load) begin
      mul_mode_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_load) begin
      acc_q <= '0;
      mc_q  <= mcand_i;
      mp_q  <= mplier_i;
    end else if (cmd_i.div_load) begin
      dq_q <= dividend_i;
      r_q  <= '0;
      dv_q <= divisor_i;
    end else if (cmd_i.step) begin
      if (mul_mode_q) begin
        acc_q <= madd;
        mp_q  <= {mp_q[SPB_W-2:0], 1'b0};
      end else begin
        dq_q <= {dq_q[DIV_W-2:0], ge};
        r_q  <= ge ? rdiff[SPB_W-1:0] : rs[SPB_W-1:0];
      end
    end
  end

  assign prod_o = acc_q;
  assign quot_o = dq_q;
  assign rem_o  = r_q;

endmodule
